/* hdl/nirb_pkg.sv */
// Package for the NEC IR to serial command bridge: types, constants, tables and microcode.
`default_nettype none
package nirb_pkg;

  localparam int TABLE_ENTRIES = 13;
  localparam int ROM_ROWS = 13;
  localparam int SEARCH_ROWS = (TABLE_ENTRIES < ROM_ROWS) ? TABLE_ENTRIES : ROM_ROWS;
  localparam int ROW_W = (ROM_ROWS > 1) ? $clog2(ROM_ROWS) : 1;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SEARCH_ROWS - 1);
  localparam logic [ROW_W-1:0] ROW_STEP = ROW_W'(1);

  localparam int UPC_W = 4;

  localparam logic [1:0] REQ_FRAME = 2'd0;
  localparam logic [1:0] REQ_REPEAT = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_REPEAT_WINDOW = 2'd1;
  localparam logic [1:0] CFG_REPEAT_HOLDOFF = 2'd2;

  localparam logic [15:0] WINDOW_RESET = 16'd1000;
  localparam logic [15:0] HOLDOFF_RESET = 16'd100;
  localparam logic [7:0] COMPLEMENT = 8'hFF;

  localparam logic [7:0] ASCII_M = 8'h6D;
  localparam logic [7:0] ASCII_C = 8'h63;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_CR = 8'h0D;

  localparam logic [UPC_W-1:0] UPC_IDLE = 4'd0;
  localparam logic [UPC_W-1:0] UPC_DISPATCH = 4'd1;
  localparam logic [UPC_W-1:0] UPC_SEARCH = 4'd2;
  localparam logic [UPC_W-1:0] UPC_RELOAD = 4'd3;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_DISPATCH,
    OP_SEARCH,
    OP_RELOAD,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    CH_M,
    CH_C,
    CH_SPACE,
    CH_ZERO,
    CH_HIGH,
    CH_LOW,
    CH_CR
  } chr_t;

  typedef struct packed {
    op_t op;
    chr_t chr;
    logic last;
    logic [UPC_W-1:0] nxt;
    logic [UPC_W-1:0] jmp;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [UPC_W-1:0] upc);
    ctrl_t w;
    w = '{op: OP_WAIT, chr: CH_M, last: 1'b0, nxt: UPC_DISPATCH, jmp: UPC_IDLE};
    unique case (upc)
      4'd0: w = '{op: OP_WAIT, chr: CH_M, last: 1'b0, nxt: UPC_DISPATCH, jmp: UPC_IDLE};
      4'd1: w = '{op: OP_DISPATCH, chr: CH_M, last: 1'b0, nxt: UPC_SEARCH, jmp: UPC_RELOAD};
      4'd2: w = '{op: OP_SEARCH, chr: CH_M, last: 1'b0, nxt: UPC_RELOAD, jmp: UPC_IDLE};
      4'd3: w = '{op: OP_RELOAD, chr: CH_M, last: 1'b0, nxt: 4'd4, jmp: UPC_IDLE};
      4'd4: w = '{op: OP_EMIT, chr: CH_M, last: 1'b0, nxt: 4'd5, jmp: UPC_IDLE};
      4'd5: w = '{op: OP_EMIT, chr: CH_C, last: 1'b0, nxt: 4'd6, jmp: UPC_IDLE};
      4'd6: w = '{op: OP_EMIT, chr: CH_SPACE, last: 1'b0, nxt: 4'd7, jmp: UPC_IDLE};
      4'd7: w = '{op: OP_EMIT, chr: CH_ZERO, last: 1'b0, nxt: 4'd8, jmp: UPC_IDLE};
      4'd8: w = '{op: OP_EMIT, chr: CH_SPACE, last: 1'b0, nxt: 4'd9, jmp: UPC_IDLE};
      4'd9: w = '{op: OP_EMIT, chr: CH_HIGH, last: 1'b0, nxt: 4'd10, jmp: UPC_IDLE};
      4'd10: w = '{op: OP_EMIT, chr: CH_LOW, last: 1'b0, nxt: 4'd11, jmp: UPC_IDLE};
      4'd11: w = '{op: OP_EMIT, chr: CH_CR, last: 1'b1, nxt: UPC_IDLE, jmp: UPC_IDLE};
      default: w = '{op: OP_WAIT, chr: CH_M, last: 1'b0, nxt: UPC_DISPATCH, jmp: UPC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] rom_key(input logic [ROW_W-1:0] row);
    logic [7:0] k;
    k = 8'h00;
    case (row)
      4'd0: k = 8'hE2;
      4'd1: k = 8'hA2;
      4'd2: k = 8'h62;
      4'd3: k = 8'hA8;
      4'd4: k = 8'hE0;
      4'd5: k = 8'h90;
      4'd6: k = 8'h38;
      4'd7: k = 8'h10;
      4'd8: k = 8'h5A;
      4'd9: k = 8'h18;
      4'd10: k = 8'h4A;
      4'd11: k = 8'hC2;
      4'd12: k = 8'h68;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] rom_code(input logic [ROW_W-1:0] row);
    logic [7:0] c;
    c = 8'h00;
    case (row)
      4'd0: c = 8'h00;
      4'd1: c = 8'h01;
      4'd2: c = 8'h08;
      4'd3: c = 8'h02;
      4'd4: c = 8'h03;
      4'd5: c = 8'h09;
      4'd6: c = 8'h44;
      4'd7: c = 8'h07;
      4'd8: c = 8'h06;
      4'd9: c = 8'h40;
      4'd10: c = 8'h41;
      4'd11: c = 8'h95;
      4'd12: c = 8'h28;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = ASCII_ZERO + {4'd0, nib};
    end else begin
      ch = ASCII_UPPER_A + {4'd0, nib} - 8'd10;
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

/* hdl/nec_ir_to_serial_command_bridge_unit.sv */
// Top level of the NEC IR to serial command bridge, a microcoded sequencer over a small datapath.
// One event at a time is taken while the sequencer sits at its idle step.
// A tick, a rejected frame or an ignored repeat passes only through the idle and dispatch steps.
// A checked frame scans the 13 rows one at a time, back to idle on a miss. A hit, or a repeat in the
// window past the hold-off, runs a reload and eight words, one per cycle if out_tready is high.
// Synchronous active-low reset clears counters, stored code and out_tvalid; loads defaults.
`default_nettype none
module nec_ir_to_serial_command_bridge_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,  // frame [31:0], elapsed_ticks [39:32]
  input  wire logic [1:0]  in_tuser,  // req_type [1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata, // out_char [7:0]
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  logic [nirb_pkg::UPC_W-1:0] upc_r, upc_nxt;
  logic [nirb_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [1:0] kind_r;
  logic [31:0] frame_r;
  logic [7:0] ticks_r;
  logic [7:0] dev_addr_r;
  logic [15:0] win_cfg_r, hold_cfg_r;
  logic [7:0] saved_r, saved_nxt;
  logic [15:0] win_r, win_nxt, hold_r, hold_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic out_last_r, out_last_nxt;
  nirb_pkg::ctrl_t cw;
  logic frame_ok;
  logic out_free;
  logic [7:0] chr_byte;

  assign cw = nirb_pkg::ucode(upc_r);
  assign in_tready = (cw.op == nirb_pkg::OP_WAIT);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;
  assign out_free = !out_valid_r || out_tready;

  assign frame_ok = ((frame_r[31:24] ^ frame_r[23:16]) == nirb_pkg::COMPLEMENT)
                 && ((frame_r[15:8] ^ frame_r[7:0]) == nirb_pkg::COMPLEMENT)
                 && (frame_r[31:24] == dev_addr_r);

  always_comb begin
    unique case (cw.chr)
      nirb_pkg::CH_M:     chr_byte = nirb_pkg::ASCII_M;
      nirb_pkg::CH_C:     chr_byte = nirb_pkg::ASCII_C;
      nirb_pkg::CH_SPACE: chr_byte = nirb_pkg::ASCII_SPACE;
      nirb_pkg::CH_ZERO:  chr_byte = nirb_pkg::ASCII_ZERO;
      nirb_pkg::CH_HIGH:  chr_byte = nirb_pkg::hex_char(saved_r[7:4]);
      nirb_pkg::CH_LOW:   chr_byte = nirb_pkg::hex_char(saved_r[3:0]);
      nirb_pkg::CH_CR:    chr_byte = nirb_pkg::ASCII_CR;
      default:            chr_byte = nirb_pkg::ASCII_CR;
    endcase
  end

  always_comb begin
    upc_nxt = upc_r;
    row_nxt = row_r;
    saved_nxt = saved_r;
    win_nxt = win_r;
    hold_nxt = hold_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    unique case (cw.op)
      nirb_pkg::OP_WAIT: begin
        if (in_tvalid) begin
          upc_nxt = cw.nxt;
        end
      end
      nirb_pkg::OP_DISPATCH: begin
        upc_nxt = nirb_pkg::UPC_IDLE;
        row_nxt = '0;
        if (kind_r == nirb_pkg::REQ_TICK) begin
          win_nxt = (win_r >= {8'd0, ticks_r}) ? win_r - {8'd0, ticks_r} : 16'd0;
          hold_nxt = (hold_r >= {8'd0, ticks_r}) ? hold_r - {8'd0, ticks_r} : 16'd0;
        end else if (kind_r == nirb_pkg::REQ_FRAME) begin
          if (frame_ok) begin
            upc_nxt = cw.nxt;
          end
        end else if (kind_r == nirb_pkg::REQ_REPEAT) begin
          if (win_r != 16'd0 && hold_r == 16'd0) begin
            upc_nxt = cw.jmp;
          end
        end
      end
      nirb_pkg::OP_SEARCH: begin
        if (nirb_pkg::rom_key(row_r) == frame_r[15:8]) begin
          saved_nxt = nirb_pkg::rom_code(row_r);
          upc_nxt = cw.nxt;
        end else if (row_r == nirb_pkg::LAST_ROW) begin
          upc_nxt = cw.jmp;
        end else begin
          row_nxt = row_r + nirb_pkg::ROW_STEP;
        end
      end
      nirb_pkg::OP_RELOAD: begin
        win_nxt = win_cfg_r;
        hold_nxt = hold_cfg_r;
        upc_nxt = cw.nxt;
      end
      nirb_pkg::OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = chr_byte;
          out_last_nxt = cw.last;
          upc_nxt = cw.nxt;
        end
      end
      default: upc_nxt = nirb_pkg::UPC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= nirb_pkg::UPC_IDLE;
      out_valid_r <= 1'b0;
      saved_r <= 8'd0;
      win_r <= 16'd0;
      hold_r <= 16'd0;
      dev_addr_r <= 8'd0;
      win_cfg_r <= nirb_pkg::WINDOW_RESET;
      hold_cfg_r <= nirb_pkg::HOLDOFF_RESET;
    end else begin
      upc_r <= upc_nxt;
      out_valid_r <= out_valid_nxt;
      saved_r <= saved_nxt;
      win_r <= win_nxt;
      hold_r <= hold_nxt;
      if (cfg_we) begin
        case (cfg_index)
          nirb_pkg::CFG_DEVICE_ADDRESS: dev_addr_r <= cfg_wdata[7:0];
          nirb_pkg::CFG_REPEAT_WINDOW:  win_cfg_r <= cfg_wdata;
          nirb_pkg::CFG_REPEAT_HOLDOFF: hold_cfg_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    if (in_tvalid && in_tready) begin
      kind_r <= in_tuser;
      frame_r <= in_tdata[31:0];
      ticks_r <= in_tdata[39:32];
    end
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (upc_r == nirb_pkg::UPC_DISPATCH))
    else $error("accepted word did not reach the dispatch step");

  a_last_is_cr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata == nirb_pkg::ASCII_CR))
    else $error("last word is not a carriage return");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == nirb_pkg::UPC_SEARCH) |-> (row_r <= nirb_pkg::LAST_ROW))
    else $error("table search ran past the last row");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r != nirb_pkg::UPC_IDLE) |-> !in_tready)
    else $error("input ready while the sequencer is busy");

endmodule
`default_nettype wire

/* dv/nirb_command_checker.sv */
// Checker that predicts the serial command words of the NEC IR bridge and compares them.
module nirb_command_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [39:0] in_tdata,  // frame [31:0], elapsed_ticks [39:32]
  input  wire logic [1:0]  in_tuser,  // req_type [1:0]
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata, // out_char [7:0]
  input  wire logic        out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  output int               fail_count,
  output int               words_owed,
  output int               commands_seen
);

  localparam int KEY_ROWS = 13;
  localparam logic [8*KEY_ROWS-1:0] KEY_COL = {
    8'h68, 8'hC2, 8'h4A, 8'h18, 8'h5A, 8'h10, 8'h38,
    8'h90, 8'hE0, 8'hA8, 8'h62, 8'hA2, 8'hE2
  };
  localparam logic [8*KEY_ROWS-1:0] CODE_COL = {
    8'h28, 8'h95, 8'h41, 8'h40, 8'h06, 8'h07, 8'h44,
    8'h09, 8'h03, 8'h02, 8'h08, 8'h01, 8'h00
  };
  localparam logic [127:0] HEX_GLYPHS = "0123456789ABCDEF";
  localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;
  localparam logic [7:0] PAIR_XOR = 8'hFF;

  typedef struct packed {
    logic [7:0] ascii;
    logic       last;
  } serial_word_t;

  logic [7:0]   dev_addr;
  logic [15:0]  window_reload;
  logic [15:0]  holdoff_reload;
  logic [7:0]   held_code;
  logic [15:0]  window_left;
  logic [15:0]  holdoff_left;
  serial_word_t pending_words[$];
  int           errors = 0;
  int           sent_cmds = 0;

  function automatic logic find_code(input logic [7:0] key, output logic [7:0] code);
    logic hit;
    hit = 1'b0;
    code = 8'h00;
    for (int r = 0; r < KEY_ROWS && r < nirb_pkg::TABLE_ENTRIES; r++) begin
      if (!hit && KEY_COL[r*8 +: 8] == key) begin
        hit = 1'b1;
        code = CODE_COL[r*8 +: 8];
      end
    end
    return hit;
  endfunction

  function automatic logic [15:0] count_down(input logic [15:0] left, input logic [7:0] ticks);
    return (left >= {8'h00, ticks}) ? left - {8'h00, ticks} : 16'h0000;
  endfunction

  function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
    return HEX_GLYPHS[(15 - int'(nib))*8 +: 8];
  endfunction

  task automatic queue_command();
    logic [63:0]  msg;
    serial_word_t w;
    msg = {"mc 0 ", hex_glyph(held_code[7:4]), hex_glyph(held_code[3:0]), CARRIAGE_RETURN};
    for (int k = 7; k >= 0; k--) begin
      w.ascii = msg[k*8 +: 8];
      w.last = (k == 0);
      pending_words.push_back(w);
    end
  endtask

  task automatic take_event(input logic [1:0] kind, input logic [31:0] frame,
                            input logic [7:0] ticks);
    logic [7:0] code;
    logic       found;
    logic       send;
    send = 1'b0;
    case (kind)
      nirb_pkg::REQ_TICK: begin
        window_left = count_down(window_left, ticks);
        holdoff_left = count_down(holdoff_left, ticks);
      end
      nirb_pkg::REQ_FRAME: begin
        found = find_code(frame[15:8], code);
        if ((frame[31:24] ^ frame[23:16]) == PAIR_XOR && (frame[15:8] ^ frame[7:0]) == PAIR_XOR
            && frame[31:24] == dev_addr && found) begin
          held_code = code;
          send = 1'b1;
        end
      end
      nirb_pkg::REQ_REPEAT: send = (window_left != 16'h0000 && holdoff_left == 16'h0000);
      default: ;
    endcase
    if (send) begin
      window_left = window_reload;
      holdoff_left = holdoff_reload;
      queue_command();
    end
  endtask

  task automatic check_word();
    serial_word_t want;
    if (pending_words.size() == 0) begin
      errors++;
      $display("%0t: unexpected word: expected none, got char %h last %b",
               $time, out_tdata, out_tlast);
    end else begin
      want = pending_words.pop_front();
      if (want.ascii !== out_tdata || want.last !== out_tlast) begin
        errors++;
        $display("%0t: word mismatch: expected char %h last %b, got char %h last %b",
                 $time, want.ascii, want.last, out_tdata, out_tlast);
      end else if (want.last) begin
        sent_cmds++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dev_addr = 8'h00;
      window_reload = 16'd1000;
      holdoff_reload = 16'd100;
      held_code = 8'h00;
      window_left = 16'h0000;
      holdoff_left = 16'h0000;
      pending_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          nirb_pkg::CFG_DEVICE_ADDRESS: dev_addr = cfg_wdata[7:0];
          nirb_pkg::CFG_REPEAT_WINDOW: window_reload = cfg_wdata;
          nirb_pkg::CFG_REPEAT_HOLDOFF: holdoff_reload = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_word();
      if (in_tvalid && in_tready) take_event(in_tuser, in_tdata[31:0], in_tdata[39:32]);
    end
    fail_count <= errors;
    words_owed <= pending_words.size();
    commands_seen <= sent_cmds;
  end

endmodule

/* dv/nec_ir_to_serial_command_bridge_unit_tb.sv */
// Testbench top for the NEC IR bridge: drives events and register settings and reports the verdict.
module nec_ir_to_serial_command_bridge_unit_tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_EVENTS = 53;
  localparam int PHASES = 6;
  localparam int ROW_BITS = nirb_pkg::ROW_W;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  typedef struct packed {
    logic [7:0]  addr;
    logic [15:0] window;
    logic [15:0] holdoff;
    logic [7:0]  tick_max;
  } setting_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  int       fail_count;
  int       words_owed;
  int       commands_seen;
  int       cycle_count = 0;
  int       events_sent = 0;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  logic [5:0] rx_tick = '0;

  nec_ir_to_serial_command_bridge_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  nirb_command_checker command_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .words_owed    (words_owed),
    .commands_seen (commands_seen)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("nec_ir_to_serial_command_bridge_unit_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    rx_tick <= rx_tick + 6'd1;
    if (rx_tick == '0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN: out_tready <= 1'b1;
      RX_COIN: out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= (rx_tick[2:0] != 3'd0 && rx_tick[2:0] != 3'd5);
    endcase
  end

  task automatic hold_idle(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      hold_idle($urandom_range(1, 12));
    end
  endtask

  task automatic send_event(input logic [1:0] kind, input logic [31:0] frame,
                            input logic [7:0] ticks);
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {ticks, frame};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    events_sent++;
    pace();
  endtask

  task automatic drain(input int settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_registers(input setting_t s);
    cfg_we <= 1'b1;
    cfg_index <= nirb_pkg::CFG_DEVICE_ADDRESS;
    cfg_wdata <= {8'h00, s.addr};
    @(posedge clk);
    cfg_index <= nirb_pkg::CFG_REPEAT_WINDOW;
    cfg_wdata <= s.window;
    @(posedge clk);
    cfg_index <= nirb_pkg::CFG_REPEAT_HOLDOFF;
    cfg_wdata <= s.holdoff;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Runs with the reset register values: device address 0, window 1000, hold-off 100.
  task automatic directed_events();
    send_event(nirb_pkg::REQ_REPEAT, 32'hFFFF_FFFF, 8'hFF);
    send_event(nirb_pkg::REQ_FRAME, 32'h00FF_E21D, 8'hFF);
    send_event(nirb_pkg::REQ_REPEAT, 32'h0000_0000, 8'h00);
    send_event(nirb_pkg::REQ_TICK, 32'hFFFF_FFFF, 8'd0);
    send_event(nirb_pkg::REQ_TICK, 32'h0000_0000, 8'd99);
    send_event(nirb_pkg::REQ_REPEAT, 32'h0000_0000, 8'h00);
    send_event(nirb_pkg::REQ_TICK, 32'h0000_0000, 8'd1);
    send_event(nirb_pkg::REQ_REPEAT, 32'h0000_0000, 8'h00);
    send_event(nirb_pkg::REQ_FRAME, 32'hFFFF_FFFF, 8'h00);
    send_event(nirb_pkg::REQ_FRAME, 32'h0000_0000, 8'h00);
    send_event(nirb_pkg::REQ_FRAME, 32'h00FE_A25D, 8'h00);
    send_event(nirb_pkg::REQ_FRAME, 32'h00FF_A25C, 8'h00);
    send_event(nirb_pkg::REQ_FRAME, 32'h01FE_A25D, 8'h00);
    send_event(nirb_pkg::REQ_FRAME, 32'h00FF_00FF, 8'h00);
    send_event(REQ_UNUSED, 32'h00FF_A25D, 8'h00);
    send_event(nirb_pkg::REQ_FRAME, 32'h00FF_6897, 8'h00);
    send_event(nirb_pkg::REQ_FRAME, 32'h00FF_C23D, 8'h00);
    repeat (4) send_event(nirb_pkg::REQ_TICK, 32'h0000_0000, 8'hFF);
    send_event(nirb_pkg::REQ_REPEAT, 32'h0000_0000, 8'h00);
    send_event(nirb_pkg::REQ_FRAME, 32'h00FF_A25D, 8'h00);
    send_event(nirb_pkg::REQ_TICK, 32'hFFFF_FFFF, 8'hFF);
    send_event(nirb_pkg::REQ_REPEAT, 32'hFFFF_FFFF, 8'hFF);
  endtask

  // Frames, mostly well-formed and for the current address, mixed with repeats, ticks up to tick_max
  // and unused request kinds, so that repeats land both inside and outside the hold-off and the window.
  task automatic random_events(input setting_t s, input int count);
    logic [7:0]  addr;
    logic [7:0]  cmd;
    logic [7:0]  ticks;
    logic [31:0] frame;
    int          pick;
    int          done;
    done = 0;
    while (done < count) begin
      addr = ($urandom_range(0, 7) != 0) ? s.addr : 8'($urandom);
      cmd = ($urandom_range(0, 4) != 0)
            ? nirb_pkg::rom_key(ROW_BITS'($urandom_range(0, nirb_pkg::ROM_ROWS - 1)))
            : 8'($urandom);
      frame = {addr, ~addr, cmd, ~cmd};
      ticks = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_event(nirb_pkg::REQ_FRAME, frame, ticks);
      end else if (pick < 48) begin
        if (pick[0]) frame = $urandom;
        else frame = frame ^ (32'd1 << $urandom_range(0, 31));
        send_event(nirb_pkg::REQ_FRAME, frame, ticks);
      end else if (pick < 72) begin
        send_event(nirb_pkg::REQ_REPEAT, $urandom, ticks);
      end else if (pick < 95) begin
        if ($urandom_range(0, 9) != 0) ticks = 8'($urandom_range(0, s.tick_max));
        send_event(nirb_pkg::REQ_TICK, $urandom, ticks);
      end else begin
        send_event(REQ_UNUSED, $urandom, ticks);
      end
      if (pick < 95) done++;
      if ($urandom_range(0, 49) == 0) drain(0);
    end
  endtask

  initial begin
    setting_t plan [PHASES];
    plan[0] = '{addr: 8'hFF, window: 16'hFFFF, holdoff: 16'h0000, tick_max: 8'd255};
    plan[1] = '{addr: 8'h00, window: 16'h0000, holdoff: 16'h0000, tick_max: 8'd255};
    plan[2] = '{addr: 8'hA5, window: 16'hFFFF, holdoff: 16'hFFFF, tick_max: 8'd255};
    plan[3] = '{addr: 8'h5A, window: 16'd300, holdoff: 16'd40, tick_max: 8'd40};
    plan[4] = '{addr: 8'h3C, window: 16'd1, holdoff: 16'h0000, tick_max: 8'd1};
    plan[5].addr = 8'($urandom);
    plan[5].window = 16'($urandom_range(50, 2000));
    plan[5].holdoff = 16'($urandom_range(0, plan[5].window / 2));
    plan[5].tick_max = 8'd64;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_events();
    drain(SETTLE_CYCLES);
    for (int p = 0; p < PHASES; p++) begin
      set_registers(plan[p]);
      random_events(plan[p], PHASE_EVENTS);
      drain(SETTLE_CYCLES);
    end

    $display("Drove %0d events under %0d register settings, reset values included.",
             events_sent, PHASES + 1);
    $display("Compared %0d complete serial commands; %0d failures found.",
             commands_seen, fail_count);
    if (fail_count == 0 && words_owed == 0) begin
      $display("nec_ir_to_serial_command_bridge_unit_tb OK");
    end else begin
      $display("nec_ir_to_serial_command_bridge_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

/* nec_ir_to_serial_command_bridge_unit.f */
hdl/nirb_pkg.sv
hdl/nec_ir_to_serial_command_bridge_unit.sv
dv/nirb_command_checker.sv
dv/nec_ir_to_serial_command_bridge_unit_tb.sv
